// File: rtl/core/ihrl_pkg.sv
// shared types, character and record codes, status codes and hex decode for the hex loader
package ihrl_pkg;

   // characters of the record text
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // record types
   localparam logic [7:0] REC_DATA       = 8'h00;
   localparam logic [7:0] REC_EOF        = 8'h01;
   localparam logic [7:0] REC_EXT_LINEAR = 8'h04;
   localparam logic [7:0] REC_START_LIN  = 8'h05;

   // end-of-line status codes
   localparam logic [3:0] ST_DATA       = 4'd0;
   localparam logic [3:0] ST_EOF        = 4'd1;
   localparam logic [3:0] ST_IGNORED    = 4'd2;
   localparam logic [3:0] ST_NO_COLON   = 4'd3;
   localparam logic [3:0] ST_HEADER_HEX = 4'd4;
   localparam logic [3:0] ST_DATA_HEX   = 4'd5;
   localparam logic [3:0] ST_SUM_HEX    = 4'd6;
   localparam logic [3:0] ST_MISMATCH   = 4'd7;
   localparam logic [3:0] ST_OVERFLOW   = 4'd8;
   localparam logic [3:0] ST_TYPE04_LEN = 4'd9;
   localparam logic [3:0] ST_TYPE05_LEN = 4'd10;

   // register index of the capacity register
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   // widths
   localparam int unsigned LEN_W = 17;
   localparam logic [LEN_W-1:0] LEN_MAX = 17'h10000;

   // result beat
   typedef struct packed {
      logic             is_status;
      logic [15:0]      write_offset;
      logic [7:0]       write_byte;
      logic [3:0]       status_code;
      logic [LEN_W-1:0] total_length;
      logic [15:0]      ext_base_high;
      logic [31:0]      start_address;
   } result_type;

   // hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// File: rtl/core/intel_hex_record_loader_core.sv
// top level of the hex record loader: beat registers, capacity register and line parser
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/ready    | kind, ch
//   rsp      | out       | rsp_valid/ready    | is_status, write_offset, write_byte,
//            |           |                    | status_code, total_length, ext_base_high,
//            |           |                    | start_address
//   csr      | in        | psel/penable/pready| capacity at byte address 0
//
// one character per cycle; a beat is decoded while it sits in the input register and its
// result is loaded into the output register at the next edge, where it stays until taken.
// reset clears the capacity, the committed length, the stop flag and all line state.
// a stalled response holds the input register; new beats are taken as soon as it moves.
module intel_hex_record_loader_core #(
   parameter int unsigned STORE_BYTES = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [7:0]                 req_ch,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_is_status,
   output logic [15:0]                rsp_write_offset,
   output logic [7:0]                 rsp_write_byte,
   output logic [3:0]                 rsp_status_code,
   output logic [ihrl_pkg::LEN_W-1:0] rsp_total_length,
   output logic [15:0]                rsp_ext_base_high,
   output logic [31:0]                rsp_start_address,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import ihrl_pkg::*;

   localparam int unsigned LIMIT_TOP = (STORE_BYTES < 65536) ? STORE_BYTES : 65536;
   localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(LIMIT_TOP);

   logic             in_valid_ff;
   logic             kind_ff;
   logic [7:0]       ch_ff;
   logic             out_valid_ff;
   result_type       out_ff;
   logic [LEN_W-1:0] capacity_ff;
   logic [LEN_W-1:0] limit_ff, limit_in;
   logic             out_free;
   logic             advance;
   logic             emit;
   result_type       result;

   // pipeline flow
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // capacity register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CAPACITY) ?
                       {{(32-LEN_W){1'b0}}, capacity_ff} : 32'd0;
   assign limit_in   = (capacity_ff < LIMIT_MAX) ? capacity_ff : LIMIT_MAX;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         limit_ff    <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_IDX_CAPACITY) begin
            capacity_ff <= csr_pwdata[LEN_W-1:0];
         end
         limit_ff <= limit_in;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         ch_ff   <= req_ch;
      end
   end

   ihrl_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .kind   (kind_ff),
      .ch     (ch_ff),
      .limit  (limit_ff),
      .emit   (emit),
      .result (result)
   );

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_status     = out_ff.is_status;
   assign rsp_write_offset  = out_ff.write_offset;
   assign rsp_write_byte    = out_ff.write_byte;
   assign rsp_status_code   = out_ff.status_code;
   assign rsp_total_length  = out_ff.total_length;
   assign rsp_ext_base_high = out_ff.ext_base_high;
   assign rsp_start_address = out_ff.start_address;

endmodule

// File: rtl/core/ihrl_parser.sv
// line parser: record state, per-character decode and result formation
module ihrl_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     kind,
   input  logic [7:0]               ch,
   input  logic [ihrl_pkg::LEN_W-1:0] limit,
   output logic                     emit,
   output ihrl_pkg::result_type     result
);
   import ihrl_pkg::*;

   typedef enum logic [2:0] {
      PH_START, PH_HEADER, PH_DATA, PH_SUM, PH_DONE, PH_SKIP, PH_IGNORED
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             pend_ff, pend_in;
   logic [3:0]       nib_ff, nib_in;
   logic [7:0]       rec_len_ff, rec_len_in;
   logic [7:0]       rec_type_ff, rec_type_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       count_ff, count_in;
   logic [3:0]       err_ff, err_in;
   logic [31:0]      collect_ff, collect_in;
   logic [LEN_W-1:0] stored_ff, stored_in;
   logic             stopped_ff, stopped_in;
   logic [15:0]      ext_base_ff, ext_base_in;
   logic [31:0]      start_ff, start_in;

   logic             eol;
   logic [4:0]       hex;
   logic [7:0]       byte_val;
   logic [7:0]       count_inc;
   logic [LEN_W:0]   offset;
   logic [LEN_W:0]   commit_sum;
   logic             is_status;
   logic [15:0]      wr_offset;
   logic [3:0]       code;

   assign eol        = (ch == CHAR_CR) || (ch == CHAR_LF);
   assign hex        = hex_digit(ch);
   assign byte_val   = {nib_ff, hex[3:0]};
   assign count_inc  = count_ff + 8'd1;
   assign offset     = {1'b0, stored_ff} + {{(LEN_W-7){1'b0}}, count_ff};
   assign commit_sum = {1'b0, stored_ff} + {{(LEN_W-7){1'b0}}, rec_len_ff};

   // next state and result of one character beat
   always_comb begin
      phase_in    = phase_ff;
      pend_in     = pend_ff;
      nib_in      = nib_ff;
      rec_len_in  = rec_len_ff;
      rec_type_in = rec_type_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      collect_in  = collect_ff;
      stored_in   = stored_ff;
      stopped_in  = stopped_ff;
      ext_base_in = ext_base_ff;
      start_in    = start_ff;
      emit        = 1'b0;
      is_status   = 1'b0;
      wr_offset   = 16'd0;
      code        = ST_DATA;
      if (step) begin
         if (kind) begin
            // restart
            phase_in   = PH_START;
            pend_in    = 1'b0;
            nib_in     = 4'd0;
            rec_len_in = 8'd0;
            rec_type_in = 8'd0;
            sum_in     = 8'd0;
            count_in   = 8'd0;
            collect_in = 32'd0;
            err_in     = ST_DATA;
            stored_in  = '0;
            stopped_in = 1'b0;
         end else if (stopped_ff) begin
            // stopped: only report the sticky code at each non-empty line end
            if (!eol) begin
               if (phase_ff == PH_START) begin
                  phase_in = PH_SKIP;
               end
            end else if (phase_ff != PH_START) begin
               phase_in    = PH_START;
               pend_in     = 1'b0;
               nib_in      = 4'd0;
               rec_len_in  = 8'd0;
               rec_type_in = 8'd0;
               sum_in      = 8'd0;
               count_in    = 8'd0;
               collect_in  = 32'd0;
               emit        = 1'b1;
               is_status   = 1'b1;
               code        = err_ff;
            end
         end else if (eol) begin
            // line end: finish the record
            if (phase_ff != PH_START) begin
               unique case (phase_ff)
                  PH_IGNORED: code = ST_IGNORED;
                  PH_HEADER:  code = ST_HEADER_HEX;
                  PH_DATA:    code = ST_DATA_HEX;
                  PH_SUM:     code = ST_SUM_HEX;
                  PH_DONE: begin
                     unique case (rec_type_ff)
                        REC_DATA: begin
                           if (commit_sum > {1'b0, limit}) begin
                              code = ST_OVERFLOW;
                           end else begin
                              code      = ST_DATA;
                              stored_in = commit_sum[LEN_W-1:0];
                           end
                        end
                        REC_EOF: code = ST_EOF;
                        REC_EXT_LINEAR: begin
                           if (rec_len_ff != 8'd2) begin
                              code = ST_TYPE04_LEN;
                           end else begin
                              code        = ST_IGNORED;
                              ext_base_in = collect_ff[15:0];
                           end
                        end
                        REC_START_LIN: begin
                           if (rec_len_ff != 8'd4) begin
                              code = ST_TYPE05_LEN;
                           end else begin
                              code     = ST_IGNORED;
                              start_in = collect_ff;
                           end
                        end
                        default: code = ST_IGNORED;
                     endcase
                  end
                  default: code = err_ff;
               endcase
               phase_in    = PH_START;
               pend_in     = 1'b0;
               nib_in      = 4'd0;
               rec_len_in  = 8'd0;
               rec_type_in = 8'd0;
               sum_in      = 8'd0;
               count_in    = 8'd0;
               collect_in  = 32'd0;
               if (code == ST_EOF || code >= ST_NO_COLON) begin
                  stopped_in = 1'b1;
                  err_in     = code;
               end else begin
                  err_in = ST_DATA;
               end
               emit      = 1'b1;
               is_status = 1'b1;
            end
         end else if (phase_ff == PH_START) begin
            // first character of a line
            if (ch == CHAR_NUL) begin
               phase_in = PH_IGNORED;
            end else if (ch == CHAR_COLON) begin
               phase_in = PH_HEADER;
            end else begin
               err_in   = ST_NO_COLON;
               phase_in = PH_SKIP;
            end
         end else if (phase_ff == PH_HEADER || phase_ff == PH_DATA || phase_ff == PH_SUM) begin
            if (!hex[4]) begin
               // non-hex inside a field
               if (phase_ff == PH_HEADER) begin
                  err_in = ST_HEADER_HEX;
               end else if (phase_ff == PH_DATA) begin
                  err_in = ST_DATA_HEX;
               end else begin
                  err_in = ST_SUM_HEX;
               end
               phase_in = PH_SKIP;
            end else if (!pend_ff) begin
               pend_in = 1'b1;
               nib_in  = hex[3:0];
            end else begin
               // full byte assembled
               pend_in = 1'b0;
               nib_in  = 4'd0;
               sum_in  = sum_ff + byte_val;
               if (phase_ff == PH_HEADER) begin
                  collect_in = {collect_ff[23:0], byte_val};
                  count_in   = count_inc;
                  if (count_inc == 8'd4) begin
                     rec_len_in  = collect_ff[23:16];
                     rec_type_in = byte_val;
                     collect_in  = 32'd0;
                     count_in    = 8'd0;
                     phase_in    = (collect_ff[23:16] != 8'd0) ? PH_DATA : PH_SUM;
                  end
               end else if (phase_ff == PH_DATA) begin
                  collect_in = {collect_ff[23:0], byte_val};
                  if (rec_type_ff == REC_DATA && offset < {1'b0, limit}) begin
                     emit      = 1'b1;
                     wr_offset = offset[15:0];
                  end
                  count_in = count_inc;
                  if (count_inc >= rec_len_ff) begin
                     phase_in = PH_SUM;
                  end
               end else if (sum_in != 8'd0) begin
                  err_in   = ST_MISMATCH;
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
      end
   end

   // result fields follow the state after this beat
   always_comb begin
      result.is_status     = is_status;
      result.write_offset  = wr_offset;
      result.write_byte    = is_status ? 8'd0 : byte_val;
      result.status_code   = is_status ? code : ST_DATA;
      result.total_length  = stored_in;
      result.ext_base_high = ext_base_in;
      result.start_address = start_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         pend_ff     <= 1'b0;
         nib_ff      <= 4'd0;
         rec_len_ff  <= 8'd0;
         rec_type_ff <= 8'd0;
         sum_ff      <= 8'd0;
         count_ff    <= 8'd0;
         err_ff      <= ST_DATA;
         collect_ff  <= 32'd0;
         stored_ff   <= '0;
         stopped_ff  <= 1'b0;
         ext_base_ff <= 16'd0;
         start_ff    <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         pend_ff     <= pend_in;
         nib_ff      <= nib_in;
         rec_len_ff  <= rec_len_in;
         rec_type_ff <= rec_type_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         err_ff      <= err_in;
         collect_ff  <= collect_in;
         stored_ff   <= stored_in;
         stopped_ff  <= stopped_in;
         ext_base_ff <= ext_base_in;
         start_ff    <= start_in;
      end
   end

endmodule

// File: rtl/core/ihrl_checker.sv
// port-level checks for the hex record loader and their bind
module ihrl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_is_status,
   input logic [15:0]                rsp_write_offset,
   input logic [7:0]                 rsp_write_byte,
   input logic [3:0]                 rsp_status_code,
   input logic [ihrl_pkg::LEN_W-1:0] rsp_total_length
);
   import ihrl_pkg::*;

   // a write beat never reports a status code
   a_write_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_status |-> rsp_status_code == ST_DATA)
      else $error("write beat carries a status code");

   // a status beat carries no write
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_status |-> rsp_write_offset == 16'd0 && rsp_write_byte == 8'd0)
      else $error("status beat carries write data");

   // tentative writes land at or past the committed length
   a_write_past_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_status |->
         {1'b0, rsp_write_offset} >= rsp_total_length)
      else $error("write below committed length");

   // committed length never exceeds the address space and the status code stays in range
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_length <= LEN_MAX && rsp_status_code <= ST_TYPE05_LEN)
      else $error("length or status out of range");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind intel_hex_record_loader_core ihrl_checker u_ihrl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_is_status    (rsp_is_status),
   .rsp_write_offset (rsp_write_offset),
   .rsp_write_byte   (rsp_write_byte),
   .rsp_status_code  (rsp_status_code),
   .rsp_total_length (rsp_total_length)
);

// File: tb/tb_top.sv
// self-checking testbench for the hex record loader: scripted lines, then random record streams
module tb_top;
   import ihrl_pkg::*;

   localparam int unsigned STORE_BYTES = 65536;
   localparam int NO_TYPED = -1;
   localparam int SETTLE_CYCLES = 4;
   localparam int NUM_PHASES = 5;
   localparam int BEATS_PER_PHASE = 270;
   localparam longint RUN_LIMIT = 64'd5_000_000;
   // stands for a nul character inside a script line
   localparam logic [7:0] NUL_MARK = 8'h7E;

   // where the parser stands within the current line
   typedef enum logic [2:0] {
      AT_START, IN_HEADER, IN_DATA, IN_SUM, LINE_DONE, SKIP_REST, LINE_IGNORED
   } line_phase_type;

   typedef enum bit {ROW_LINE, ROW_CAPACITY} row_op_type;

   typedef struct {
      row_op_type op;
      bit         restart_first;
      string      text;
      logic [7:0] eol;
      int         code;
      logic [16:0] cap;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_status;
   logic [15:0] rsp_write_offset;
   logic [7:0]  rsp_write_byte;
   logic [3:0]  rsp_status_code;
   logic [LEN_W-1:0] rsp_total_length;
   logic [15:0] rsp_ext_base_high;
   logic [31:0] rsp_start_address;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the loader state
   logic [16:0]    cap_reg;
   line_phase_type phase;
   logic [4:0]     pend_nib;
   logic [7:0]     rec_len;
   logic [7:0]     rec_type;
   logic [7:0]     sum_acc;
   logic [7:0]     byte_cnt;
   logic [3:0]     sticky_code;
   logic [31:0]    collect;
   logic [16:0]    committed;
   logic           halted;
   logic [15:0]    ext_hi;
   logic [31:0]    entry_addr;

   result_type due_results [$];
   int mismatches = 0;
   int live_beats = 0;
   int gap_pct = 0;
   int ready_hold = 0;
   bit calm = 1'b0;

   script_row_type script_rows [23] = '{
      '{ROW_CAPACITY, 1'b0, "", CHAR_LF, NO_TYPED, 17'd0},
      '{ROW_LINE, 1'b0, ":0100000041BE", CHAR_LF, ST_OVERFLOW, 17'd0},
      '{ROW_LINE, 1'b0, ":00000001FF", CHAR_CR, ST_OVERFLOW, 17'd0},
      '{ROW_CAPACITY, 1'b0, "", CHAR_LF, NO_TYPED, 17'h10000},
      '{ROW_LINE, 1'b1, "", CHAR_LF, NO_TYPED, 17'd0},
      '{ROW_LINE, 1'b0, "~ABC", CHAR_CR, ST_IGNORED, 17'd0},
      '{ROW_LINE, 1'b0, ":0300300002337A1E", CHAR_LF, ST_DATA, 17'd0},
      '{ROW_LINE, 1'b0, ":02000000ffab54xyz", CHAR_CR, ST_DATA, 17'd0},
      '{ROW_LINE, 1'b0, ":020000040800F2", CHAR_LF, ST_IGNORED, 17'd0},
      '{ROW_LINE, 1'b0, ":0400000512345678E3", CHAR_LF, ST_IGNORED, 17'd0},
      '{ROW_LINE, 1'b0, ":0100000201FC", CHAR_CR, ST_IGNORED, 17'd0},
      '{ROW_LINE, 1'b0, ":00000003FD", CHAR_LF, ST_IGNORED, 17'd0},
      '{ROW_LINE, 1'b0, ":0100000400FB", CHAR_LF, ST_TYPE04_LEN, 17'd0},
      '{ROW_LINE, 1'b1, ":02000005ABCD81", CHAR_LF, ST_TYPE05_LEN, 17'd0},
      '{ROW_LINE, 1'b1, "X:00", CHAR_CR, ST_NO_COLON, 17'd0},
      '{ROW_LINE, 1'b1, ":00G0", CHAR_LF, ST_HEADER_HEX, 17'd0},
      '{ROW_LINE, 1'b1, ":0100000041", CHAR_LF, ST_SUM_HEX, 17'd0},
      '{ROW_LINE, 1'b1, ":01000000~1", CHAR_LF, ST_DATA_HEX, 17'd0},
      '{ROW_LINE, 1'b1, ":0100000041BF", CHAR_CR, ST_MISMATCH, 17'd0},
      '{ROW_LINE, 1'b1, ":00000001ff", CHAR_LF, ST_EOF, 17'd0},
      '{ROW_CAPACITY, 1'b0, "", CHAR_LF, NO_TYPED, 17'd2},
      '{ROW_LINE, 1'b1, ":03000000AABBCCCC", CHAR_LF, ST_OVERFLOW, 17'd0},
      '{ROW_LINE, 1'b1, ":01", CHAR_CR, ST_HEADER_HEX, 17'd0}
   };

   intel_hex_record_loader_core #(
      .STORE_BYTES(STORE_BYTES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_status     (rsp_is_status),
      .rsp_write_offset  (rsp_write_offset),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_status_code   (rsp_status_code),
      .rsp_total_length  (rsp_total_length),
      .rsp_ext_base_high (rsp_ext_base_high),
      .rsp_start_address (rsp_start_address),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // value of a hex digit character, -1 for anything else
   function automatic int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 4'd10) return 8'("0" + n);
      return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
   endfunction

   // bytes that may be written: least of capacity, store size and 64k
   function automatic logic [16:0] store_limit();
      logic [16:0] m;
      m = cap_reg;
      if (STORE_BYTES < m) m = 17'(STORE_BYTES);
      if (m > LEN_MAX) m = LEN_MAX;
      return m;
   endfunction

   function automatic result_type make_result(logic st, logic [15:0] off, logic [7:0] b,
                                              logic [3:0] code);
      result_type r;
      r.is_status     = st;
      r.write_offset  = off;
      r.write_byte    = b;
      r.status_code   = code;
      r.total_length  = committed;
      r.ext_base_high = ext_hi;
      r.start_address = entry_addr;
      return r;
   endfunction

   function automatic void clear_line_state();
      phase    = AT_START;
      pend_nib = '0;
      rec_len  = '0;
      rec_type = '0;
      sum_acc  = '0;
      byte_cnt = '0;
      collect  = '0;
   endfunction

   // end-of-line handling of a record whose checksum matched
   function automatic logic [3:0] close_record();
      logic [17:0] grown;
      grown = committed + rec_len;
      case (rec_type)
         REC_DATA: begin
            if (grown > store_limit()) return ST_OVERFLOW;
            committed = grown[16:0];
            return ST_DATA;
         end
         REC_EOF: return ST_EOF;
         REC_EXT_LINEAR: begin
            if (rec_len != 8'd2) return ST_TYPE04_LEN;
            ext_hi = collect[15:0];
            return ST_IGNORED;
         end
         REC_START_LIN: begin
            if (rec_len != 8'd4) return ST_TYPE05_LEN;
            entry_addr = collect;
            return ST_IGNORED;
         end
         default: return ST_IGNORED;
      endcase
   endfunction

   // advance the predicted loader by one accepted beat
   task automatic step_loader(input logic kind, input logic [7:0] ch,
                              output bit has, output result_type r);
      bit eol;
      int nib;
      logic [3:0] code;
      logic [7:0] b;
      logic [17:0] off;
      eol = (ch == CHAR_CR) || (ch == CHAR_LF);
      has = 1'b0;
      r = make_result(1'b0, 16'd0, 8'd0, ST_DATA);
      // restart clears the committed length and the stop flag
      if (kind) begin
         clear_line_state();
         sticky_code = ST_DATA;
         committed = '0;
         halted = 1'b0;
         return;
      end
      // stopped: each non-empty line repeats the sticky code
      if (halted) begin
         if (!eol) begin
            if (phase == AT_START) phase = SKIP_REST;
            return;
         end
         if (phase == AT_START) return;
         clear_line_state();
         has = 1'b1;
         r = make_result(1'b1, 16'd0, 8'd0, sticky_code);
         return;
      end
      // end of line
      if (eol) begin
         case (phase)
            AT_START:     return;
            LINE_IGNORED: code = ST_IGNORED;
            IN_HEADER:    code = ST_HEADER_HEX;
            IN_DATA:      code = ST_DATA_HEX;
            IN_SUM:       code = ST_SUM_HEX;
            LINE_DONE:    code = close_record();
            default:      code = sticky_code;
         endcase
         clear_line_state();
         if (code == ST_EOF || code >= ST_NO_COLON) begin
            halted = 1'b1;
            sticky_code = code;
         end else begin
            sticky_code = ST_DATA;
         end
         has = 1'b1;
         r = make_result(1'b1, 16'd0, 8'd0, code);
         return;
      end
      // first character of a line
      if (phase == AT_START) begin
         if (ch == CHAR_NUL) begin
            phase = LINE_IGNORED;
         end else if (ch == CHAR_COLON) begin
            phase = IN_HEADER;
         end else begin
            sticky_code = ST_NO_COLON;
            phase = SKIP_REST;
         end
         return;
      end
      if (phase != IN_HEADER && phase != IN_DATA && phase != IN_SUM) return;
      nib = digit_value(ch);
      if (nib < 0) begin
         sticky_code = (phase == IN_HEADER) ? ST_HEADER_HEX :
                       (phase == IN_DATA) ? ST_DATA_HEX : ST_SUM_HEX;
         phase = SKIP_REST;
         return;
      end
      // pair nibbles into bytes
      if (!pend_nib[4]) begin
         pend_nib = {1'b1, 4'(nib)};
         return;
      end
      b = {pend_nib[3:0], 4'(nib)};
      pend_nib = '0;
      sum_acc = sum_acc + b;
      if (phase == IN_HEADER) begin
         collect = {collect[23:0], b};
         byte_cnt = byte_cnt + 8'd1;
         if (byte_cnt == 8'd4) begin
            rec_len = collect[31:24];
            rec_type = collect[7:0];
            collect = '0;
            byte_cnt = '0;
            phase = (rec_len != 8'd0) ? IN_DATA : IN_SUM;
         end
         return;
      end
      // data bytes are written out as they arrive, while below the limit
      if (phase == IN_DATA) begin
         off = committed + byte_cnt;
         collect = {collect[23:0], b};
         if (rec_type == REC_DATA && off < store_limit()) begin
            has = 1'b1;
            r = make_result(1'b0, off[15:0], b, ST_DATA);
         end
         byte_cnt = byte_cnt + 8'd1;
         if (byte_cnt >= rec_len) phase = IN_SUM;
         return;
      end
      // checksum byte
      if (sum_acc != 8'd0) begin
         sticky_code = ST_MISMATCH;
         phase = SKIP_REST;
      end else begin
         phase = LINE_DONE;
      end
   endtask

   // drive one beat, wait for it to be taken and record what it should cause
   task automatic send_beat(input logic kind, input logic [7:0] ch, input int typed);
      bit has;
      result_type r;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      live_beats++;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_ch    <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_loader(kind, ch, has, r);
      if (typed >= 0) begin
         r = make_result(1'b1, 16'd0, 8'd0, 4'(typed));
         has = 1'b1;
      end
      if (has) due_results.push_back(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // capacity write once idle, then read back
   task automatic write_capacity(input logic [16:0] v);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * CSR_IDX_CAPACITY);
      csr_pwdata  <= {15'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cap_reg = v;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {15'd0, v}) begin
         $error("capacity: expected %0h, got %0h", v, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one record line with random content, now and then broken
   task automatic send_random_line();
      logic [7:0] rec [$];
      logic [7:0] text [$];
      logic [7:0] rtype;
      logic [7:0] csum;
      int len;
      int pick;
      int flaw;
      int pos;
      int restart_at;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         rtype = REC_DATA;
         len = ($urandom_range(0, 99) < 3) ? $urandom_range(100, 255) : $urandom_range(0, 16);
      end else if (pick < 76) begin
         rtype = REC_EOF;
         len = $urandom_range(0, 1);
      end else if (pick < 84) begin
         rtype = REC_EXT_LINEAR;
         len = ($urandom_range(0, 3) != 0) ? 2 : $urandom_range(0, 5);
      end else if (pick < 92) begin
         rtype = REC_START_LIN;
         len = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 6);
      end else begin
         rtype = 8'($urandom_range(2, 255));
         len = $urandom_range(0, 8);
      end
      rec.push_back(8'(len));
      rec.push_back(8'($urandom));
      rec.push_back(8'($urandom));
      rec.push_back(rtype);
      repeat (len) rec.push_back(8'($urandom));
      csum = 8'd0;
      foreach (rec[i]) csum = csum - rec[i];
      rec.push_back(csum);
      text.push_back(CHAR_COLON);
      foreach (rec[i]) begin
         text.push_back(hex_char(rec[i][7:4], bit'($urandom_range(0, 1))));
         text.push_back(hex_char(rec[i][3:0], bit'($urandom_range(0, 1))));
      end
      // damage about one line in five
      restart_at = -1;
      flaw = $urandom_range(0, 99);
      if (flaw >= 80) begin
         case (flaw % 7)
            0: text[text.size() - 1] = hex_char(csum[3:0] ^ 4'($urandom_range(1, 15)), 1'b0);
            1: begin
               pos = $urandom_range(1, text.size() - 1);
               text[pos] = 8'($urandom);
            end
            2: begin
               pos = $urandom_range(0, text.size() - 1);
               while (text.size() > pos) void'(text.pop_back());
            end
            3: begin
               do text[0] = 8'($urandom); while (text[0] == CHAR_COLON);
            end
            4: text[0] = CHAR_NUL;
            5: restart_at = $urandom_range(0, text.size() - 1);
            default: repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(32, 126)));
         endcase
      end
      case ($urandom_range(0, 2))
         0: text.push_back(CHAR_CR);
         1: text.push_back(CHAR_LF);
         default: begin
            text.push_back(CHAR_CR);
            text.push_back(CHAR_LF);
         end
      endcase
      case ($urandom_range(0, 3))
         0, 1: gap_pct = 0;
         2: gap_pct = 10;
         default: gap_pct = 35;
      endcase
      for (int i = 0; i < text.size(); i++) begin
         if (i == restart_at) send_beat(1'b1, 8'($urandom), NO_TYPED);
         send_beat(1'b0, text[i], NO_TYPED);
      end
   endtask

   // result side stalls in random bursts
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_ready <= 1'b0;
         ready_hold = $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 11);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // compare each result beat with the oldest one due
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result beat with nothing due: status %0d code %0d",
                   rsp_is_status, rsp_status_code);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("is_status", want.is_status, rsp_is_status);
            check_field("write_offset", want.write_offset, rsp_write_offset);
            check_field("write_byte", want.write_byte, rsp_write_byte);
            check_field("status_code", want.status_code, rsp_status_code);
            check_field("total_length", want.total_length, rsp_total_length);
            check_field("ext_base_high", want.ext_base_high, rsp_ext_base_high);
            check_field("start_address", want.start_address, rsp_start_address);
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [7:0] ch;
      logic [16:0] cap;
      cap_reg = '0;
      clear_line_state();
      sticky_code = ST_DATA;
      committed = '0;
      halted = 1'b0;
      ext_hi = '0;
      entry_addr = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // scripted lines
      gap_pct = 20;
      foreach (script_rows[k]) begin
         if (script_rows[k].op == ROW_CAPACITY) begin
            write_capacity(script_rows[k].cap);
         end else begin
            if (script_rows[k].restart_first) send_beat(1'b1, 8'hFF, NO_TYPED);
            for (int i = 0; i < script_rows[k].text.len(); i++) begin
               ch = script_rows[k].text[i];
               if (ch == NUL_MARK) ch = CHAR_NUL;
               send_beat(1'b0, ch, NO_TYPED);
            end
            send_beat(1'b0, script_rows[k].eol, script_rows[k].code);
         end
      end

      // random record streams under several capacities
      live_beats = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: cap = LEN_MAX;
            1: cap = 17'($urandom_range(0, 48));
            2: cap = 17'd1;
            3: cap = 17'($urandom_range(0, 65536));
            default: cap = LEN_MAX;
         endcase
         write_capacity(cap);
         calm = (p == NUM_PHASES - 1);
         while (live_beats < (p + 1) * BEATS_PER_PHASE) begin
            if ((halted && $urandom_range(0, 4) != 0) || $urandom_range(0, 49) == 0) begin
               send_beat(1'b1, 8'($urandom), NO_TYPED);
            end else if ($urandom_range(0, 19) == 0) begin
               repeat ($urandom_range(1, 20)) send_beat(1'b0, 8'($urandom), NO_TYPED);
               send_beat(1'b0, CHAR_LF, NO_TYPED);
            end else begin
               send_random_line();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
